FILE: hw/rtl/ecv_pkg.sv
package ecv_pkg;

    localparam int NUM_ROUTES = 8;
    localparam int NUM_SLOTS  = 16;

    localparam int RW = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_END   = 2'd1;
    localparam logic [1:0] FUNC_CTRL  = 2'd2;
    localparam logic [1:0] FUNC_BLOCK = 2'd3;

    localparam logic [1:0] KIND_GATE  = 2'd0;
    localparam logic [1:0] KIND_PITCH = 2'd1;
    localparam logic [1:0] KIND_CTRL  = 2'd2;

    localparam logic ST_SEGMENT = 1'b0;
    localparam logic ST_FULL    = 1'b1;

    localparam logic [1:0] REG_BLOCK_FRAMES = 2'd0;
    localparam logic [1:0] REG_VOLTS_OCT    = 2'd1;
    localparam logic [1:0] REG_VOLTS_REF    = 2'd2;
    localparam logic [1:0] REG_REF_SEMIS    = 2'd3;

    localparam logic signed [19:0] UNIT_ONE = 20'sd4096;
    localparam logic [4:0] HELD_MAX = 5'd31;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SC_RD, S_SC_CMP, S_ST_GATE, S_ST_PITCH, S_END,
        S_CTRL, S_FULL, S_BLK_RD, S_BLK_G, S_BLK_P, S_BLK_C
    } t_state;

    typedef struct packed {
        logic               gate;
        logic signed [19:0] pitch;
        logic [12:0]        ctrl;
        logic [12:0]        org_val;
        logic [11:0]        org_frame;
        logic [4:0]         held;
    } t_route;

    typedef struct packed {
        logic [15:0] voice;
        logic [2:0]  route;
        logic [15:0] trig;
    } t_slot;

    typedef struct packed {
        logic          we;
        logic          set_valid;
        logic          clr_valid;
        logic [SW-1:0] addr;
        t_slot         entry;
    } t_slot_wr;

    typedef struct packed {
        logic               status;
        logic [2:0]         route;
        logic [1:0]         kind;
        logic [11:0]        sf;
        logic [11:0]        ef;
        logic signed [19:0] sv;
        logic signed [19:0] ev;
        logic               last;
    } t_seg;

endpackage

FILE: hw/rtl/event_to_control_voltage_router.sv
// channel      dir  handshake                  payload
// s_axis       in   s_axis_tvalid/tready       tdata event fields, tuser func
// m_axis       out  m_axis_tvalid/tready       tdata segment, tuser status+kind, tlast
// apb          in   psel/penable/pwrite        four config registers at 4*i
//
// an event word is taken only in idle; a note start or end scans the trigger
// table slot by slot, read then compare; a control change emits one segment,
// a block start emits a gate, pitch and ctrl segment for every route
// the one-word output register lets the next event in while a segment waits
// reset is synchronous and clears route and slot valid bits, no clearing pass
// a stalled output holds the sequencer in its emit state
module event_to_control_voltage_router import ecv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // route_index, voice_id, trigger_id, has_pitch, pitch_semitones,
    // control_value, linear_ramp, frame_offset, zero pad
    input  logic [87:0] s_axis_tdata,
    // func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // route_out, start_frame, end_frame, start_value, end_value, zero pad
    output logic [71:0] m_axis_tdata,
    // status, signal_kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [12:0]        r_block_frames;
    logic [15:0]        r_vpo;
    logic signed [19:0] r_var;
    logic signed [15:0] r_ref;

    // latched event
    logic [1:0]         r_func;
    logic [2:0]         r_route_in;
    logic [15:0]        r_voice;
    logic [15:0]        r_trig;
    logic               r_has_pitch;
    logic signed [15:0] r_semis;
    logic signed [15:0] r_cval;
    logic               r_linear;
    logic [11:0]        r_frame;

    // sequencer
    t_state             r_state, n_state;
    logic [SW-1:0]      r_sidx;
    logic               r_released;
    logic [RW-1:0]      r_cur_route;
    logic               r_out_valid;
    t_seg               r_out;

    // route memory
    t_route             r_route_mem [NUM_ROUTES];
    logic [NUM_ROUTES-1:0] r_route_ok;
    t_route             r_route_q;
    logic               r_route_q_ok;
    t_route             rt_q;
    logic               rt_we;
    t_route             rt_wdata;

    // slot table
    t_slot_wr           slot_wr;
    t_slot              slot_q;
    logic [NUM_SLOTS-1:0] slot_valid;

    logic signed [19:0] volts;
    logic               s_acc;
    logic               out_free;
    logic               emit;
    t_seg               seg;
    logic               cfg_wr;
    logic               slot_last;
    logic               slot_free;
    logic               slot_match;
    logic               route_last;
    logic [4:0]         new_cnt;
    logic [12:0]        ctrl_next;
    logic [12:0]        frames;
    logic [12:0]        lim;
    logic [11:0]        frame_in;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;

    assign rt_q       = r_route_q_ok ? r_route_q : '0;
    assign slot_last  = (r_sidx == SW'(NUM_SLOTS - 1));
    assign slot_free  = !slot_valid[r_sidx];
    assign slot_match = slot_valid[r_sidx] && slot_q.voice == r_voice
                        && slot_q.route == r_route_in && slot_q.trig == r_trig;
    assign route_last = (r_cur_route == RW'(NUM_ROUTES - 1));

    // event frame clamps to the block
    always_comb begin
        if (r_block_frames == 13'd0)
            frames = 13'd1;
        else if (r_block_frames > 13'd4096)
            frames = 13'd4096;
        else
            frames = r_block_frames;
        lim = frames - 13'd1;
        if (s_axis_tdata[84:69] < {3'b000, lim})
            frame_in = s_axis_tdata[80:69];
        else
            frame_in = lim[11:0];
    end

    always_comb begin
        if (r_cval < 16'sd0)
            ctrl_next = 13'd0;
        else if (r_cval > 16'sd4096)
            ctrl_next = 13'd4096;
        else
            ctrl_next = r_cval[12:0];
    end

    always_comb begin
        if (r_released && rt_q.held != 5'd0)
            new_cnt = rt_q.held - 5'd1;
        else
            new_cnt = rt_q.held;
    end

    ecv_pitch u_pitch (
        .i_clk   (i_clk),
        .i_semis (r_semis),
        .i_ref   (r_ref),
        .i_vpo   (r_vpo),
        .i_var   (r_var),
        .o_volts (volts)
    );

    ecv_slot_table u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_sidx),
        .i_wr      (slot_wr),
        .o_rd_data (slot_q),
        .o_valid   (slot_valid)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_axis_tuser == FUNC_BLOCK)
                        n_state = S_BLK_RD;
                    else if (5'(s_axis_tdata[2:0]) < 5'(NUM_ROUTES))
                        n_state = S_RD;
                end
            end
            S_RD:      n_state = (r_func == FUNC_CTRL) ? S_CTRL : S_SC_RD;
            S_SC_RD:   n_state = S_SC_CMP;
            S_SC_CMP: begin
                if (r_func == FUNC_START) begin
                    if (slot_free)
                        n_state = S_ST_GATE;
                    else if (slot_last)
                        n_state = S_FULL;
                    else
                        n_state = S_SC_RD;
                end else begin
                    if (slot_match || slot_last)
                        n_state = S_END;
                    else
                        n_state = S_SC_RD;
                end
            end
            S_ST_GATE: if (out_free) n_state = r_has_pitch ? S_ST_PITCH : S_IDLE;
            S_ST_PITCH: if (out_free) n_state = S_IDLE;
            S_END: begin
                if (new_cnt != 5'd0 || out_free)
                    n_state = S_IDLE;
            end
            S_CTRL:    if (out_free) n_state = S_IDLE;
            S_FULL:    if (out_free) n_state = S_IDLE;
            S_BLK_RD:  n_state = S_BLK_G;
            S_BLK_G:   if (out_free) n_state = S_BLK_P;
            S_BLK_P:   if (out_free) n_state = S_BLK_C;
            S_BLK_C:   if (out_free) n_state = route_last ? S_IDLE : S_BLK_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs of each state
    always_comb begin
        emit     = 1'b0;
        seg      = '0;
        seg.route = r_route_in;
        rt_we    = 1'b0;
        rt_wdata = rt_q;
        slot_wr  = '0;
        slot_wr.addr = r_sidx;
        slot_wr.entry.voice = r_voice;
        slot_wr.entry.route = r_route_in;
        slot_wr.entry.trig  = r_trig;
        case (r_state)
            S_SC_CMP: begin
                if (r_func == FUNC_START && slot_free) begin
                    slot_wr.we        = 1'b1;
                    slot_wr.set_valid = 1'b1;
                end else if (r_func == FUNC_END && slot_match) begin
                    slot_wr.clr_valid = 1'b1;
                end
            end
            S_ST_GATE: begin
                emit     = out_free;
                seg.kind = KIND_GATE;
                seg.sf   = r_frame;
                seg.ef   = r_frame;
                seg.sv   = UNIT_ONE;
                seg.ev   = UNIT_ONE;
                seg.last = !r_has_pitch;
                rt_we    = out_free;
                rt_wdata.gate = 1'b1;
                if (rt_q.held < HELD_MAX)
                    rt_wdata.held = rt_q.held + 5'd1;
                if (r_has_pitch)
                    rt_wdata.pitch = volts;
            end
            S_ST_PITCH: begin
                emit     = out_free;
                seg.kind = KIND_PITCH;
                seg.sf   = r_frame;
                seg.ef   = r_frame;
                seg.sv   = volts;
                seg.ev   = volts;
                seg.last = 1'b1;
            end
            S_END: begin
                seg.kind = KIND_GATE;
                seg.sf   = r_frame;
                seg.ef   = r_frame;
                seg.last = 1'b1;
                rt_wdata.held = new_cnt;
                if (new_cnt == 5'd0) begin
                    emit  = out_free;
                    rt_we = out_free;
                    rt_wdata.gate = 1'b0;
                end else begin
                    rt_we = 1'b1;
                end
            end
            S_CTRL: begin
                emit     = out_free;
                seg.kind = KIND_CTRL;
                seg.last = 1'b1;
                seg.ev   = 20'(ctrl_next);
                if (r_linear && r_frame > rt_q.org_frame) begin
                    seg.sf = rt_q.org_frame;
                    seg.sv = 20'(rt_q.org_val);
                end else begin
                    seg.sf = r_frame;
                    seg.sv = 20'(ctrl_next);
                end
                seg.ef   = r_frame;
                rt_we    = out_free;
                rt_wdata.ctrl      = ctrl_next;
                rt_wdata.org_val   = ctrl_next;
                rt_wdata.org_frame = r_frame;
            end
            S_FULL: begin
                emit       = out_free;
                seg.status = ST_FULL;
                seg.last   = 1'b1;
            end
            S_BLK_G: begin
                emit      = out_free;
                seg.route = 3'(r_cur_route);
                seg.kind  = KIND_GATE;
                seg.sv    = rt_q.gate ? UNIT_ONE : 20'sd0;
                seg.ev    = rt_q.gate ? UNIT_ONE : 20'sd0;
            end
            S_BLK_P: begin
                emit      = out_free;
                seg.route = 3'(r_cur_route);
                seg.kind  = KIND_PITCH;
                seg.sv    = rt_q.pitch;
                seg.ev    = rt_q.pitch;
            end
            S_BLK_C: begin
                emit      = out_free;
                seg.route = 3'(r_cur_route);
                seg.kind  = KIND_CTRL;
                seg.sv    = 20'(rt_q.ctrl);
                seg.ev    = 20'(rt_q.ctrl);
                seg.last  = route_last;
                rt_we     = out_free;
                rt_wdata.org_val   = rt_q.ctrl;
                rt_wdata.org_frame = 12'd0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // route memory, read address follows the current route
    always_ff @(posedge i_clk) begin
        if (rt_we)
            r_route_mem[r_cur_route] <= rt_wdata;
        r_route_q <= r_route_mem[r_cur_route];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_ok   <= '0;
            r_route_q_ok <= 1'b0;
        end else begin
            r_route_q_ok <= r_route_ok[r_cur_route];
            if (rt_we)
                r_route_ok[r_cur_route] <= 1'b1;
        end
    end

    // event latch and output segment register
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_func      <= s_axis_tuser;
            r_route_in  <= s_axis_tdata[2:0];
            r_voice     <= s_axis_tdata[18:3];
            r_trig      <= s_axis_tdata[34:19];
            r_has_pitch <= s_axis_tdata[35];
            r_semis     <= s_axis_tdata[51:36];
            r_cval      <= s_axis_tdata[67:52];
            r_linear    <= s_axis_tdata[68];
            r_frame     <= frame_in;
        end
        if (emit)
            r_out <= seg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sidx      <= '0;
            r_released  <= 1'b0;
            r_cur_route <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_sidx     <= '0;
                r_released <= 1'b0;
                r_cur_route <= (s_axis_tuser == FUNC_BLOCK) ? '0
                                                            : RW'(s_axis_tdata[2:0]);
            end
            if (r_state == S_SC_CMP) begin
                if (slot_match)
                    r_released <= 1'b1;
                if (!slot_last)
                    r_sidx <= r_sidx + SW'(1);
            end
            if (r_state == S_BLK_C && out_free && !route_last)
                r_cur_route <= r_cur_route + RW'(1);
            if (emit)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_frames <= 13'd256;
            r_vpo          <= 16'd4096;
            r_var          <= 20'sd0;
            r_ref          <= 16'sd15360;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BLOCK_FRAMES: r_block_frames <= pwdata[12:0];
                REG_VOLTS_OCT:    r_vpo          <= pwdata[15:0];
                REG_VOLTS_REF:    r_var          <= pwdata[19:0];
                REG_REF_SEMIS:    r_ref          <= pwdata[15:0];
                default:          r_vpo          <= r_vpo;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BLOCK_FRAMES: prdata = 32'(r_block_frames);
            REG_VOLTS_OCT:    prdata = 32'(r_vpo);
            REG_VOLTS_REF:    prdata = {12'd0, r_var};
            REG_REF_SEMIS:    prdata = {16'd0, r_ref};
            default:          prdata = 32'd0;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.ev, r_out.sv, r_out.ef, r_out.sf, r_out.route};
    assign m_axis_tuser  = {r_out.kind, r_out.status};
    assign m_axis_tlast  = r_out.last;

endmodule

FILE: hw/rtl/ecv_pitch.sv
module ecv_pitch import ecv_pkg::*; (
    input  logic               i_clk,
    input  logic signed [15:0] i_semis,
    input  logic signed [15:0] i_ref,
    input  logic [15:0]        i_vpo,
    input  logic signed [19:0] i_var,
    output logic signed [19:0] o_volts
);

    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [32:0]        r_prod;
    logic               r_neg1;
    logic [33:0]        biased;
    logic [31:0]        x;
    logic [63:0]        recip;
    logic [20:0]        r_q;
    logic               r_neg2;
    logic signed [22:0] sum;
    logic signed [19:0] r_volts;

    // divide by 3072: shift by 1024 then multiply by reciprocal of three
    always_comb begin
        diff   = 17'(i_semis) - 17'(i_ref);
        mag    = diff[16] ? 17'(-diff) : 17'(diff);
        biased = 34'(r_prod) + 34'd1536;
        x      = 32'(biased >> 10);
        recip  = 64'(x) * 64'h0000_0000_AAAA_AAAB;
        sum    = (r_neg2 ? -23'(r_q) : 23'(r_q)) + 23'(i_var);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 33'(mag) * 33'(i_vpo);
        r_neg1 <= diff[16];
        r_q    <= recip[53:33];
        r_neg2 <= r_neg1;
        if (sum < -23'sd524288)
            r_volts <= -20'sd524288;
        else if (sum > 23'sd524287)
            r_volts <= 20'sd524287;
        else
            r_volts <= sum[19:0];
    end

    assign o_volts = r_volts;

endmodule

FILE: hw/rtl/ecv_slot_table.sv
module ecv_slot_table import ecv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SW-1:0]        i_rd_addr,
    input  t_slot_wr             i_wr,
    output t_slot                o_rd_data,
    output logic [NUM_SLOTS-1:0] o_valid
);

    t_slot                r_mem [NUM_SLOTS];
    t_slot                r_rd_data;
    logic [NUM_SLOTS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we)
            r_mem[i_wr.addr] <= i_wr.entry;
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.set_valid) begin
            r_valid[i_wr.addr] <= 1'b1;
        end else if (i_wr.clr_valid) begin
            r_valid[i_wr.addr] <= 1'b0;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_valid   = r_valid;

endmodule
